[src/ers_pkg.sv]
// shared types and constants for the elevator request scheduler
`timescale 1ns / 1ps
package ers_pkg;

  localparam int FLOORS  = 7;
  localparam int FLOOR_W = 3;
  localparam int ADDR_W  = 5;

  localparam logic [15:0] DEBOUNCE_RST = 16'd100;
  localparam logic [15:0] START_RST    = 16'd2000;
  localparam logic [15:0] DEPART_RST   = 16'd3000;
  localparam logic [15:0] TRAVEL_RST   = 16'd1260;
  localparam logic [15:0] DWELL_RST    = 16'd1000;
  localparam logic [11:0] THRESH_RST   = 12'd114;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DEPART = 2'd1,
    PH_TRAVEL = 2'd2,
    PH_DWELL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CURSOR  = 3'd1,
    EV_TOGGLE  = 3'd2,
    EV_DEPART  = 3'd3,
    EV_PASS    = 3'd4,
    EV_STOP    = 3'd5,
    EV_END     = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE = 3'd0,
    REG_START    = 3'd1,
    REG_DEPART   = 3'd2,
    REG_TRAVEL   = 3'd3,
    REG_DWELL    = 3'd4,
    REG_THRESH   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] button_level;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [FLOOR_W-1:0] floor_now;
    logic [FLOOR_W-1:0] cursor_floor;
    logic [FLOORS-1:0]  request_mask;
    logic              busy_res;
    logic              heading_up;
  } rsp_beat_t;

endpackage

[src/elevator_request_scheduler_top.sv]
// Elevator request scheduler: one state update per beat and a registered result.
// Takes one tick or press beat per clock cycle; its result appears in the output
// register on the next cycle. The whole floor, cursor, request and trip-timer
// update happens in one registered stage. A new beat enters in the same cycle the
// previous result leaves; while a result waits under rsp_stall the input stalls too.
// Configuration registers sit on the APB-style port at byte address 4*index.
`timescale 1ns / 1ps
module elevator_request_scheduler_top
  import ers_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_beat_t         cmd_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_beat_t         rsp_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration
  logic [15:0] debounce_ticks, start_delay_ticks, depart_delay_ticks;
  logic [15:0] floor_travel_ticks, end_dwell_ticks;
  logic [11:0] button_threshold;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  // state
  logic [TIME_WIDTH-1:0] tick_time, last_press_time;
  logic                  start_pending;
  phase_t                trip_phase, trip_phase_next;
  logic [15:0]           phase_timer;
  logic [FLOOR_W-1:0]    cabin_floor, cursor_pos, target_floor;
  logic [FLOORS-1:0]     requests;
  logic                  going_up;

  logic [TIME_WIDTH-1:0] tick_time_next, last_press_time_next;
  logic                  start_pending_next;
  logic [15:0]           phase_timer_next;
  logic [FLOOR_W-1:0]    cabin_floor_next, cursor_pos_next, target_floor_next;
  logic [FLOORS-1:0]     requests_next;
  logic                  going_up_next;
  logic [2:0]            event_next;

  // datapath helpers
  logic                  accept, is_tick;
  logic [TIME_WIDTH-1:0] tick_inc, elapsed_tick, elapsed_press;
  logic                  press_ok, start_go;
  logic [15:0]           timer_inc, limit;
  logic                  timer_hit;
  logic [FLOOR_W-1:0]    cabin_step, search_cabin, found_floor;
  logic [FLOORS-1:0]     req_arrive, search_req;
  logic                  arrive, found, found_up, found_above, found_below;
  logic [FLOOR_W-1:0]    above_floor, below_floor;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DEBOUNCE_RST;
      start_delay_ticks  <= START_RST;
      depart_delay_ticks <= DEPART_RST;
      floor_travel_ticks <= TRAVEL_RST;
      end_dwell_ticks    <= DWELL_RST;
      button_threshold   <= THRESH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE: debounce_ticks     <= pwdata[15:0];
        REG_START:    start_delay_ticks  <= pwdata[15:0];
        REG_DEPART:   depart_delay_ticks <= pwdata[15:0];
        REG_TRAVEL:   floor_travel_ticks <= pwdata[15:0];
        REG_DWELL:    end_dwell_ticks    <= pwdata[15:0];
        REG_THRESH:   button_threshold   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = {16'd0, debounce_ticks};
      REG_START:    prdata = {16'd0, start_delay_ticks};
      REG_DEPART:   prdata = {16'd0, depart_delay_ticks};
      REG_TRAVEL:   prdata = {16'd0, floor_travel_ticks};
      REG_DWELL:    prdata = {16'd0, end_dwell_ticks};
      REG_THRESH:   prdata = {20'd0, button_threshold};
      default:      prdata = 32'd0;
    endcase
  end

  // handshake
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign is_tick   = !cmd_data.kind;

  // time and timer
  assign tick_inc      = tick_time + TIME_WIDTH'(1);
  assign elapsed_tick  = tick_inc - last_press_time;
  assign elapsed_press = tick_time - last_press_time;
  assign press_ok      = elapsed_press > TIME_WIDTH'(debounce_ticks);
  assign start_go      = (trip_phase == PH_IDLE) && start_pending &&
                         (elapsed_tick > TIME_WIDTH'(start_delay_ticks));
  assign timer_inc     = (&phase_timer) ? phase_timer : phase_timer + 16'd1;

  always_comb begin
    case (trip_phase)
      PH_DEPART: limit = depart_delay_ticks;
      PH_TRAVEL: limit = floor_travel_ticks;
      PH_DWELL:  limit = end_dwell_ticks;
      default:   limit = 16'd0;
    endcase
  end
  assign timer_hit = timer_inc >= limit;

  // cabin movement
  always_comb begin
    if (going_up) begin
      cabin_step = (cabin_floor < FLOOR_W'(FLOORS - 1)) ? cabin_floor + FLOOR_W'(1)
                                                        : cabin_floor;
    end else begin
      cabin_step = (cabin_floor != '0) ? cabin_floor - FLOOR_W'(1) : cabin_floor;
    end
  end
  assign arrive     = cabin_step == target_floor;
  assign req_arrive = requests & ~(FLOORS'(1) << cabin_step);

  // next target search: nearest above, else nearest below
  assign search_cabin = (trip_phase == PH_TRAVEL) ? cabin_step : cabin_floor;
  assign search_req   = (trip_phase == PH_TRAVEL) ? req_arrive : requests;

  always_comb begin
    found_above = 1'b0;
    above_floor = '0;
    for (int f = FLOORS - 1; f >= 0; f--) begin
      if (search_req[f] && (f > int'(search_cabin))) begin
        found_above = 1'b1;
        above_floor = FLOOR_W'(f);
      end
    end
  end

  always_comb begin
    found_below = 1'b0;
    below_floor = '0;
    for (int f = 0; f < FLOORS; f++) begin
      if (search_req[f] && (f < int'(search_cabin))) begin
        found_below = 1'b1;
        below_floor = FLOOR_W'(f);
      end
    end
  end

  assign found       = found_above || found_below;
  assign found_up    = found_above;
  assign found_floor = found_above ? above_floor : below_floor;

  // trip phase next state
  always_comb begin
    trip_phase_next = trip_phase;
    if (is_tick) begin
      case (trip_phase)
        PH_IDLE: begin
          if (start_go) begin
            trip_phase_next = found ? PH_DEPART : PH_DWELL;
          end
        end
        PH_DEPART: begin
          if (timer_hit) begin
            trip_phase_next = PH_TRAVEL;
          end
        end
        PH_TRAVEL: begin
          if (timer_hit && arrive) begin
            trip_phase_next = found ? PH_DEPART : PH_DWELL;
          end
        end
        PH_DWELL: begin
          if (timer_hit) begin
            trip_phase_next = PH_IDLE;
          end
        end
        default: trip_phase_next = PH_IDLE;
      endcase
    end
  end

  // datapath next values and event
  always_comb begin
    tick_time_next       = tick_time;
    last_press_time_next = last_press_time;
    start_pending_next   = start_pending;
    phase_timer_next     = phase_timer;
    cabin_floor_next     = cabin_floor;
    cursor_pos_next      = cursor_pos;
    target_floor_next    = target_floor;
    requests_next        = requests;
    going_up_next        = going_up;
    event_next           = EV_NONE;
    if (is_tick) begin
      tick_time_next = tick_inc;
      case (trip_phase)
        PH_IDLE: begin
          if (start_go) begin
            start_pending_next = 1'b0;
            phase_timer_next   = '0;
            if (found) begin
              target_floor_next = found_floor;
              going_up_next     = found_up;
            end
          end
        end
        PH_DEPART: begin
          phase_timer_next = timer_hit ? 16'd0 : timer_inc;
          if (timer_hit) begin
            event_next = EV_DEPART;
          end
        end
        PH_TRAVEL: begin
          phase_timer_next = timer_hit ? 16'd0 : timer_inc;
          if (timer_hit) begin
            cabin_floor_next = cabin_step;
            if (arrive) begin
              requests_next = req_arrive;
              event_next    = EV_STOP;
              if (found) begin
                target_floor_next = found_floor;
                going_up_next     = found_up;
              end
            end else begin
              event_next = EV_PASS;
            end
          end
        end
        PH_DWELL: begin
          phase_timer_next = timer_hit ? 16'd0 : timer_inc;
          if (timer_hit) begin
            event_next = EV_END;
          end
        end
        default: ;
      endcase
    end else if (press_ok) begin
      last_press_time_next = tick_time;
      if (trip_phase == PH_IDLE) begin
        start_pending_next = 1'b1;
        if (cmd_data.button_level >= button_threshold) begin
          cursor_pos_next = (cursor_pos == FLOOR_W'(FLOORS - 1)) ? '0
                                                                 : cursor_pos + FLOOR_W'(1);
          event_next      = EV_CURSOR;
        end else begin
          if (cursor_pos == cabin_floor) begin
            requests_next = requests & ~(FLOORS'(1) << cursor_pos);
          end else begin
            requests_next = requests ^ (FLOORS'(1) << cursor_pos);
          end
          event_next = EV_TOGGLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_time       <= '0;
      last_press_time <= '0;
      start_pending   <= 1'b0;
      trip_phase      <= PH_IDLE;
      phase_timer     <= '0;
      cabin_floor     <= '0;
      cursor_pos      <= '0;
      target_floor    <= '0;
      requests        <= '0;
      going_up        <= 1'b0;
    end else if (accept) begin
      tick_time       <= tick_time_next;
      last_press_time <= last_press_time_next;
      start_pending   <= start_pending_next;
      trip_phase      <= trip_phase_next;
      phase_timer     <= phase_timer_next;
      cabin_floor     <= cabin_floor_next;
      cursor_pos      <= cursor_pos_next;
      target_floor    <= target_floor_next;
      requests        <= requests_next;
      going_up        <= going_up_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data.event_res    <= event_next;
      rsp_data.floor_now    <= cabin_floor_next;
      rsp_data.cursor_floor <= cursor_pos_next;
      rsp_data.request_mask <= requests_next;
      rsp_data.busy_res     <= trip_phase_next != PH_IDLE;
      rsp_data.heading_up   <= going_up_next;
    end
  end

  // checks
  a_cabin_not_requested: assert property (@(posedge clk) disable iff (rst)
    !requests[cabin_floor])
    else $error("cabin floor left requested");

  a_no_pending_in_trip: assert property (@(posedge clk) disable iff (rst)
    (trip_phase != PH_IDLE) |-> !start_pending)
    else $error("start pending during trip");

  a_floor_range: assert property (@(posedge clk) disable iff (rst)
    (cabin_floor < FLOOR_W'(FLOORS)) && (cursor_pos < FLOOR_W'(FLOORS)))
    else $error("floor index out of range");

  a_depart_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.event_res == EV_DEPART || rsp_data.event_res == EV_PASS)
    |-> rsp_data.busy_res)
    else $error("trip beat without busy");

  a_press_in_trip_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_data.kind && (trip_phase != PH_IDLE)
    |=> (rsp_data.event_res == EV_NONE) && $stable(requests) && $stable(cursor_pos))
    else $error("press changed state during trip");

endmodule
